[sv/dlr_pkg.sv]
// ---------------------------------------------------------------------------
// dlr_pkg
// shared widths, constants, codes and control structs of the line rasterizer
// ---------------------------------------------------------------------------
package dlr_pkg;

	localparam int COORD_W   = 16;
	localparam int FRAC_W    = 16;
	localparam int ACC_W     = COORD_W + 1 + FRAC_W;   // accumulator, Q17.16
	localparam int INC_W     = FRAC_W + 2;             // signed per-step increment
	localparam int STEP_W    = COORD_W + 1;
	localparam int T_W       = FRAC_W + 1;             // line parameter, up to 1.0
	localparam int HGT_W     = 16;
	localparam int COLOR_W   = 24;
	localparam int IDX_W     = 24;
	localparam int FDIM_W    = 13;
	localparam int DIVD_W    = 41;                     // dividend / quotient
	localparam int DIVS_W    = 17;                     // divisor
	localparam int CNT_W     = $clog2(DIVD_W + 1);
	localparam int HUE_W     = FRAC_W + 7;
	localparam int BPROD_W   = 9 + T_W + 1;
	localparam int ZPROD_W   = (HGT_W + 1) + (T_W + 1);
	localparam int Z_W       = HGT_W + FRAC_W + 5;

	localparam logic [HUE_W-1:0]   HUE_MAX = HUE_W'(120 << FRAC_W);
	localparam logic [HUE_W-1:0]   SIXTY   = HUE_W'(60 << FRAC_W);
	localparam logic [ACC_W:0]     HALF_FX = (ACC_W+1)'(1) << (FRAC_W - 1);
	localparam logic [DIVD_W-1:0]  ONE_FX  = DIVD_W'(1) << FRAC_W;
	localparam logic [COLOR_W-1:0] CYAN    = 24'h0FFFFF;
	localparam logic [COLOR_W-1:0] WHITE   = 24'hFFFFFF;

	localparam logic MODE_LOAD = 1'b0;

	typedef enum logic [1:0] {
		CM_CONST = 2'd0,
		CM_BLEND = 2'd1,
		CM_HUE   = 2'd2,
		CM_WHITE = 2'd3
	} color_mode_t;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_COLOR_MODE   = 3'd2,
		REG_LOWEST       = 3'd3,
		REG_HIGHEST      = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEL_X = 2'd0,
		SEL_Y = 2'd1,
		SEL_F = 2'd2,
		SEL_H = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic [FDIM_W-1:0] frame_width;
		logic [FDIM_W-1:0] frame_height;
		color_mode_t       color_mode;
		logic [HGT_W-1:0]  lowest_height;
		logic [HGT_W-1:0]  highest_height;
	} dlr_cfg_t;

	typedef struct packed {
		logic     capture;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_store;
		logic     activate;
		logic     pix_s1;
		logic     pix_s2;
		logic     pix_s3;
		logic     commit;
	} dlr_cmd_t;

	typedef struct packed {
		logic steps_zero;
		logic line_active;
		logic div_done;
		logic need_hue_div;
		logic out_full;
	} dlr_status_t;

endpackage

[sv/dlr_div.sv]
// ---------------------------------------------------------------------------
// dlr_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module dlr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dlr_pkg::DIVD_W-1:0] dividend,
	input  logic [dlr_pkg::DIVS_W-1:0] divisor,
	output logic [dlr_pkg::DIVD_W-1:0] quotient,
	output logic                       done
);

	logic [dlr_pkg::DIVD_W-1:0] quot_q;
	logic [dlr_pkg::DIVS_W-1:0] rem_q;
	logic [dlr_pkg::DIVS_W-1:0] dvs_q;
	logic [dlr_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [dlr_pkg::DIVS_W:0]   trial;
	logic                       fits;
	logic [dlr_pkg::DIVS_W:0]   diff;

	assign trial = {rem_q, quot_q[dlr_pkg::DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= dlr_pkg::CNT_W'(dlr_pkg::DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dlr_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload side, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[dlr_pkg::DIVD_W-2:0], fits};
			rem_q  <= fits ? diff[dlr_pkg::DIVS_W-1:0] : trial[dlr_pkg::DIVS_W-1:0];
		end
	end

	assign quotient = quot_q;
	assign done     = done_q;

endmodule

[sv/dlr_datapath.sv]
// ---------------------------------------------------------------------------
// dlr_datapath
// line state, step arithmetic, colour stages and the output register
// ---------------------------------------------------------------------------
module dlr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dlr_pkg::dlr_cmd_t             cmd,
	output dlr_pkg::dlr_status_t          stat,
	input  dlr_pkg::dlr_cfg_t             cfg,
	input  logic [dlr_pkg::COORD_W-1:0]   x_start,
	input  logic [dlr_pkg::COORD_W-1:0]   y_start,
	input  logic [dlr_pkg::COORD_W-1:0]   x_end,
	input  logic [dlr_pkg::COORD_W-1:0]   y_end,
	input  logic [dlr_pkg::COLOR_W-1:0]   color_start,
	input  logic [dlr_pkg::COLOR_W-1:0]   color_end,
	input  logic [dlr_pkg::HGT_W-1:0]     height_start,
	input  logic [dlr_pkg::HGT_W-1:0]     height_end,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [dlr_pkg::COORD_W-1:0]   pixel_x,
	output logic [dlr_pkg::COORD_W-1:0]   pixel_y,
	output logic [dlr_pkg::IDX_W-1:0]     pixel_index,
	output logic                          in_frame,
	output logic [dlr_pkg::COLOR_W-1:0]   pixel_color,
	output logic                          last
);

	localparam int CW   = dlr_pkg::COORD_W;
	localparam int FW   = dlr_pkg::FRAC_W;
	localparam int Z_WL = dlr_pkg::Z_W;

	// line state
	logic                               line_active_q;
	logic signed [dlr_pkg::ACC_W-1:0]   x_acc_q, y_acc_q;
	logic signed [dlr_pkg::INC_W-1:0]   x_inc_q, y_inc_q;
	logic [dlr_pkg::STEP_W-1:0]         step_idx_q, step_tot_q;
	logic [dlr_pkg::T_W-1:0]            finc_q, facc_q;
	logic [CW-1:0]                      ax_q, ay_q;
	logic                               dx_neg_q, dy_neg_q;
	logic [dlr_pkg::COLOR_W-1:0]        color_a_q, color_b_q;
	logic [dlr_pkg::HGT_W-1:0]          height_a_q, height_b_q;

	// capture arithmetic
	logic signed [CW:0] dx, dy;
	logic [CW:0]        adx, ady;

	assign dx  = $signed({x_end[CW-1], x_end}) - $signed({x_start[CW-1], x_start});
	assign dy  = $signed({y_end[CW-1], y_end}) - $signed({y_start[CW-1], y_start});
	assign adx = dx[CW] ? -dx : dx;
	assign ady = dy[CW] ? -dy : dy;

	// height range
	logic signed [dlr_pkg::HGT_W:0] den;
	logic [dlr_pkg::DIVS_W-1:0]     den_mag;
	logic                           den_zero;

	assign den      = $signed({cfg.highest_height[dlr_pkg::HGT_W-1], cfg.highest_height})
	                - $signed({cfg.lowest_height[dlr_pkg::HGT_W-1], cfg.lowest_height});
	assign den_mag  = den[dlr_pkg::HGT_W] ? dlr_pkg::DIVS_W'(-den) : dlr_pkg::DIVS_W'(den);
	assign den_zero = (den == '0);

	// shared divider
	logic [dlr_pkg::DIVD_W-1:0] div_dvd, div_quot;
	logic [dlr_pkg::DIVS_W-1:0] div_dvs;
	logic                       div_done;
	logic [dlr_pkg::DIVD_W-1:0] hue_num_s2;

	always_comb begin
		div_dvs = dlr_pkg::DIVS_W'(step_tot_q);
		unique case (cmd.div_sel)
			dlr_pkg::SEL_X: div_dvd = dlr_pkg::DIVD_W'({ax_q, {FW{1'b0}}})
			                        + dlr_pkg::DIVD_W'(step_tot_q >> 1);
			dlr_pkg::SEL_Y: div_dvd = dlr_pkg::DIVD_W'({ay_q, {FW{1'b0}}})
			                        + dlr_pkg::DIVD_W'(step_tot_q >> 1);
			dlr_pkg::SEL_F: div_dvd = dlr_pkg::ONE_FX;
			dlr_pkg::SEL_H: begin
				div_dvd = hue_num_s2;
				div_dvs = den_mag;
			end
			default: div_dvd = '0;
		endcase
	end

	dlr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quot),
		.done     (div_done)
	);

	logic [dlr_pkg::T_W-1:0]  quot_mag;
	logic [dlr_pkg::INC_W-1:0] inc_pos;

	assign quot_mag = div_quot[dlr_pkg::T_W-1:0];
	assign inc_pos  = {1'b0, quot_mag};

	// stage 1: rounding, last mark, products
	logic signed [dlr_pkg::ACC_W:0]       xr, yr;
	logic signed [dlr_pkg::BPROD_W-1:0]   bprod [3];
	logic signed [dlr_pkg::HGT_W:0]       hdiff;
	logic signed [dlr_pkg::ZPROD_W-1:0]   zprod;
	logic signed [CW:0]                   px_s1, py_s1;
	logic                                 fin_s1;
	logic signed [dlr_pkg::BPROD_W-1:0]   bprod_s1 [3];
	logic signed [dlr_pkg::ZPROD_W-1:0]   zprod_s1;

	assign xr    = $signed({x_acc_q[dlr_pkg::ACC_W-1], x_acc_q}) + $signed(dlr_pkg::HALF_FX);
	assign yr    = $signed({y_acc_q[dlr_pkg::ACC_W-1], y_acc_q}) + $signed(dlr_pkg::HALF_FX);
	assign hdiff = $signed({height_b_q[dlr_pkg::HGT_W-1], height_b_q})
	             - $signed({height_a_q[dlr_pkg::HGT_W-1], height_a_q});
	assign zprod = hdiff * $signed({1'b0, facc_q});

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			bprod[ch] = $signed({1'b0, color_b_q[8*ch +: 8]} - {1'b0, color_a_q[8*ch +: 8]})
			          * $signed({1'b0, facc_q});
		end
	end

	// stage 2: clipping, frame index, blend, hue numerator
	logic                         frame_hit;
	logic [2*dlr_pkg::FDIM_W-1:0] row_base;
	logic [2*dlr_pkg::FDIM_W-1:0] idx_sum;
	logic [dlr_pkg::COLOR_W-1:0]  blend_c;
	logic signed [dlr_pkg::BPROD_W-1:0] badj [3];
	logic signed [Z_WL-1:0]       z_val;
	logic signed [Z_WL-1:0]       w_val;
	logic [Z_WL-1:0]              w_mag;
	logic                         inside_s2;
	logic [dlr_pkg::IDX_W-1:0]    idx_s2;
	logic [dlr_pkg::COLOR_W-1:0]  blend_s2;
	logic                         hue_neg_s2;

	assign frame_hit = !px_s1[CW] && !py_s1[CW]
	                && (px_s1[CW-1:0] < CW'(cfg.frame_width))
	                && (py_s1[CW-1:0] < CW'(cfg.frame_height));
	assign row_base = py_s1[dlr_pkg::FDIM_W-1:0] * cfg.frame_width;
	assign idx_sum  = row_base + (2*dlr_pkg::FDIM_W)'(px_s1[dlr_pkg::FDIM_W-1:0]);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			// truncate toward zero
			badj[ch] = bprod_s1[ch] + (bprod_s1[ch][dlr_pkg::BPROD_W-1]
			         ? dlr_pkg::BPROD_W'({FW{1'b1}}) : dlr_pkg::BPROD_W'(0));
			blend_c[8*ch +: 8] = color_a_q[8*ch +: 8] + badj[ch][FW +: 8];
		end
	end

	assign z_val = $signed({{(Z_WL-dlr_pkg::HGT_W-FW){height_a_q[dlr_pkg::HGT_W-1]}},
	                        height_a_q, {FW{1'b0}}})
	             + $signed(Z_WL'(zprod_s1));
	assign w_val = z_val
	             - $signed({{(Z_WL-dlr_pkg::HGT_W-FW){cfg.lowest_height[dlr_pkg::HGT_W-1]}},
	                        cfg.lowest_height, {FW{1'b0}}});
	assign w_mag = w_val[Z_WL-1] ? -w_val : w_val;

	// stage 3: hue clamp and sector colour
	logic [dlr_pkg::HUE_W-1:0]   hue;
	logic [dlr_pkg::HUE_W-1:0]   hsel;
	logic [dlr_pkg::HUE_W+4:0]   hmul;
	logic [7:0]                  hr, hg, hfrac;
	logic [dlr_pkg::COLOR_W-1:0] color_s3;

	always_comb begin
		if (den_zero || hue_neg_s2) begin
			hue = dlr_pkg::HUE_MAX;
		end else if (div_quot >= dlr_pkg::DIVD_W'(dlr_pkg::HUE_MAX)) begin
			hue = '0;
		end else begin
			hue = dlr_pkg::HUE_MAX - div_quot[dlr_pkg::HUE_W-1:0];
		end
		hsel  = (hue < dlr_pkg::SIXTY) ? hue : (dlr_pkg::HUE_MAX - hue);
		// x * 255 / (60 << F) is x * 17 >> (F + 2)
		hmul  = ((dlr_pkg::HUE_W+5)'(hsel) << 4) + (dlr_pkg::HUE_W+5)'(hsel);
		hfrac = hmul[FW+2 +: 8];
		if (hue < dlr_pkg::SIXTY) begin
			hr = 8'hFF;
			hg = hfrac;
		end else begin
			hr = hfrac;
			hg = 8'hFF;
		end
	end

	// output register
	logic                        out_valid_q;
	logic [CW-1:0]               out_x_q, out_y_q;
	logic [dlr_pkg::IDX_W-1:0]   out_idx_q;
	logic                        out_in_q, out_last_q;
	logic [dlr_pkg::COLOR_W-1:0] out_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
			x_acc_q       <= '0;
			y_acc_q       <= '0;
			x_inc_q       <= '0;
			y_inc_q       <= '0;
			step_idx_q    <= '0;
			step_tot_q    <= '0;
			finc_q        <= '0;
			facc_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.capture) begin
				line_active_q <= 1'b0;
				x_acc_q       <= {x_start[CW-1], x_start, {FW{1'b0}}};
				y_acc_q       <= {y_start[CW-1], y_start, {FW{1'b0}}};
				step_idx_q    <= '0;
				facc_q        <= '0;
				x_inc_q       <= '0;
				y_inc_q       <= '0;
				finc_q        <= '0;
				step_tot_q    <= (adx > ady) ? adx : ady;
			end
			if (cmd.div_store) begin
				unique case (cmd.div_sel)
					dlr_pkg::SEL_X: x_inc_q <= dx_neg_q ? -inc_pos : inc_pos;
					dlr_pkg::SEL_Y: y_inc_q <= dy_neg_q ? -inc_pos : inc_pos;
					dlr_pkg::SEL_F: finc_q  <= quot_mag;
					default: ;
				endcase
			end
			if (cmd.activate) begin
				line_active_q <= 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				x_acc_q     <= x_acc_q + dlr_pkg::ACC_W'(x_inc_q);
				y_acc_q     <= y_acc_q + dlr_pkg::ACC_W'(y_inc_q);
				step_idx_q  <= step_idx_q + 1'b1;
				facc_q      <= facc_q + finc_q;
				if (fin_s1) begin
					line_active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ax_q       <= adx[CW-1:0];
			ay_q       <= ady[CW-1:0];
			dx_neg_q   <= dx[CW];
			dy_neg_q   <= dy[CW];
			color_a_q  <= color_start;
			color_b_q  <= color_end;
			height_a_q <= height_start;
			height_b_q <= height_end;
		end
		if (cmd.pix_s1) begin
			px_s1    <= xr[FW +: CW+1];
			py_s1    <= yr[FW +: CW+1];
			fin_s1   <= dlr_pkg::STEP_W'(step_idx_q + 1'b1) >= step_tot_q;
			bprod_s1 <= bprod;
			zprod_s1 <= zprod;
		end
		if (cmd.pix_s2) begin
			inside_s2  <= frame_hit;
			idx_s2     <= frame_hit ? idx_sum[dlr_pkg::IDX_W-1:0] : '0;
			blend_s2   <= blend_c;
			hue_num_s2 <= (dlr_pkg::DIVD_W'(w_mag) << 7) - (dlr_pkg::DIVD_W'(w_mag) << 3);
			hue_neg_s2 <= w_val[Z_WL-1] ^ den[dlr_pkg::HGT_W];
		end
		if (cmd.pix_s3) begin
			unique case (cfg.color_mode)
				dlr_pkg::CM_CONST: color_s3 <= dlr_pkg::CYAN;
				dlr_pkg::CM_BLEND: color_s3 <= blend_s2;
				dlr_pkg::CM_HUE:   color_s3 <= {hr, hg, 8'h00};
				dlr_pkg::CM_WHITE: color_s3 <= dlr_pkg::WHITE;
				default:           color_s3 <= dlr_pkg::WHITE;
			endcase
		end
		if (cmd.commit) begin
			out_x_q     <= px_s1[CW-1:0];
			out_y_q     <= py_s1[CW-1:0];
			out_idx_q   <= idx_s2;
			out_in_q    <= inside_s2;
			out_color_q <= color_s3;
			out_last_q  <= fin_s1;
		end
	end

	assign stat.steps_zero   = (step_tot_q == '0);
	assign stat.line_active  = line_active_q;
	assign stat.div_done     = div_done;
	assign stat.need_hue_div = (cfg.color_mode == dlr_pkg::CM_HUE) && !den_zero;
	assign stat.out_full     = out_valid_q;

	assign out_valid   = out_valid_q;
	assign pixel_x     = out_x_q;
	assign pixel_y     = out_y_q;
	assign pixel_index = out_idx_q;
	assign in_frame    = out_in_q;
	assign pixel_color = out_color_q;
	assign last        = out_last_q;

endmodule

[sv/dlr_ctrl.sv]
// ---------------------------------------------------------------------------
// dlr_ctrl
// sequencer for line setup divisions and the per-pixel stages
// ---------------------------------------------------------------------------
module dlr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_mode,
	input  dlr_pkg::dlr_status_t stat,
	output dlr_pkg::dlr_cmd_t    cmd,
	output logic                 in_stall
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV_X,
		ST_DIV_Y,
		ST_DIV_F,
		ST_PIX1,
		ST_PIX2,
		ST_DIV_H,
		ST_PIX3,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_mode == dlr_pkg::MODE_LOAD) begin
							state_q <= ST_CALC;
						end else if (stat.line_active) begin
							state_q <= ST_PIX1;
						end
					end
				end
				ST_CALC: begin
					if (stat.steps_zero) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV_X;
						start_q <= 1'b1;
					end
				end
				ST_DIV_X: begin
					if (stat.div_done) begin
						state_q <= ST_DIV_Y;
						start_q <= 1'b1;
					end
				end
				ST_DIV_Y: begin
					if (stat.div_done) begin
						state_q <= ST_DIV_F;
						start_q <= 1'b1;
					end
				end
				ST_DIV_F: begin
					if (stat.div_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PIX1: state_q <= ST_PIX2;
				ST_PIX2: begin
					if (stat.need_hue_div) begin
						state_q <= ST_DIV_H;
						start_q <= 1'b1;
					end else begin
						state_q <= ST_PIX3;
					end
				end
				ST_DIV_H: begin
					if (stat.div_done) begin
						state_q <= ST_PIX3;
					end
				end
				ST_PIX3: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					if (!stat.out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic in_div_setup;

	assign in_div_setup = (state_q == ST_DIV_X) || (state_q == ST_DIV_Y)
	                   || (state_q == ST_DIV_F);

	assign in_stall      = (state_q != ST_IDLE);
	assign cmd.capture   = in_valid && (state_q == ST_IDLE) && (in_mode == dlr_pkg::MODE_LOAD);
	assign cmd.div_start = start_q;
	assign cmd.div_sel   = (state_q == ST_DIV_X) ? dlr_pkg::SEL_X :
	                       (state_q == ST_DIV_Y) ? dlr_pkg::SEL_Y :
	                       (state_q == ST_DIV_F) ? dlr_pkg::SEL_F : dlr_pkg::SEL_H;
	assign cmd.div_store = in_div_setup && stat.div_done;
	assign cmd.activate  = (state_q == ST_DIV_F) && stat.div_done;
	assign cmd.pix_s1    = (state_q == ST_PIX1);
	assign cmd.pix_s2    = (state_q == ST_PIX2);
	assign cmd.pix_s3    = (state_q == ST_PIX3);
	assign cmd.commit    = (state_q == ST_COMMIT) && !stat.out_full;

endmodule

[sv/dda_line_rasterizer_unit.sv]
// ---------------------------------------------------------------------------
// dda_line_rasterizer_unit
// dda line rasterizer: load a line, then one pixel per step beat
// ---------------------------------------------------------------------------
// latency: a step beat gives its pixel through states PIX1, PIX2, PIX3 and COMMIT, with a
//   divider pass (DIV_H) after PIX2 in hue mode with a nonzero height range
// a load beat holds in_stall through CALC and, for a nonzero-length line, three divider passes
// throughput: one item at a time; in_stall stays high until the current beat is done,
//   including any wait on a full output register; setup and hue share one divider
// reset: arst_n clears control, line state and output valid; config registers
//   return to width 1024, height 768, mode 0, heights 0..255
// ---------------------------------------------------------------------------
module dda_line_rasterizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	// apb config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [15:0] x_start,
	input  logic [15:0] y_start,
	input  logic [15:0] x_end,
	input  logic [15:0] y_end,
	input  logic [23:0] color_start,
	input  logic [23:0] color_end,
	input  logic [15:0] height_start,
	input  logic [15:0] height_end,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [23:0] pixel_index,
	output logic        in_frame,
	output logic [23:0] pixel_color,
	output logic        last
);

	// config registers, to be written by the user only while idle; the block does not enforce it
	dlr_pkg::dlr_cfg_t cfg_q;
	dlr_pkg::reg_idx_t reg_sel;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = dlr_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width    <= 13'd1024;
			cfg_q.frame_height   <= 13'd768;
			cfg_q.color_mode     <= dlr_pkg::CM_CONST;
			cfg_q.lowest_height  <= 16'd0;
			cfg_q.highest_height <= 16'd255;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				dlr_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width    <= pwdata[12:0];
				dlr_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height   <= pwdata[12:0];
				dlr_pkg::REG_COLOR_MODE:
					cfg_q.color_mode <= dlr_pkg::color_mode_t'(pwdata[1:0]);
				dlr_pkg::REG_LOWEST:       cfg_q.lowest_height  <= pwdata[15:0];
				dlr_pkg::REG_HIGHEST:      cfg_q.highest_height <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_sel)
			dlr_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_q.frame_width);
			dlr_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_q.frame_height);
			dlr_pkg::REG_COLOR_MODE:   prdata = 32'(cfg_q.color_mode);
			dlr_pkg::REG_LOWEST:       prdata = 32'(cfg_q.lowest_height);
			dlr_pkg::REG_HIGHEST:      prdata = 32'(cfg_q.highest_height);
			default:                   prdata = 32'd0;
		endcase
	end

	// controller and datapath talk only through these
	dlr_pkg::dlr_cmd_t    cmd;
	dlr_pkg::dlr_status_t stat;

	dlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (mode),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	dlr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg          (cfg_q),
		.x_start      (x_start),
		.y_start      (y_start),
		.x_end        (x_end),
		.y_end        (y_end),
		.color_start  (color_start),
		.color_end    (color_end),
		.height_start (height_start),
		.height_end   (height_end),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_index  (pixel_index),
		.in_frame     (in_frame),
		.pixel_color  (pixel_color),
		.last         (last)
	);

endmodule

[sv/dlr_checker.sv]
// ---------------------------------------------------------------------------
// dlr_checker
// port-level checks on the line rasterizer
// ---------------------------------------------------------------------------
module dlr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        mode,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] pixel_x,
	input logic [15:0] pixel_y,
	input logic [23:0] pixel_index,
	input logic        in_frame,
	input logic [23:0] pixel_color
);

	// a load beat always starts setup work
	a_load_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode == dlr_pkg::MODE_LOAD) |=> in_stall)
		else $error("load beat did not start setup");

	a_frame_coords: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_frame |-> !pixel_x[15] && !pixel_y[15])
		else $error("in-frame pixel with negative coordinate");

	a_clip_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_frame |-> pixel_index == 24'd0)
		else $error("clipped pixel with nonzero index");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_color) && $stable(pixel_x))
		else $error("stalled output beat changed");

endmodule

bind dda_line_rasterizer_unit dlr_checker u_dlr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.mode        (mode),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.pixel_index (pixel_index),
	.in_frame    (in_frame),
	.pixel_color (pixel_color)
);

[verif/dda_line_rasterizer_unit_tb.sv]
// ---------------------------------------------------------------------------
// dda_line_rasterizer_unit_tb
// self-checking bench: random lines and pixel steps under every color mode,
// with random idling on both channels and checks against a built-in predictor
// ---------------------------------------------------------------------------

// pixel beat as seen on the output channel
typedef struct packed {
	logic [15:0] px;
	logic [15:0] py;
	logic [23:0] idx;
	logic        hit;
	logic [23:0] color;
	logic        fin;
} pixel_beat_t;

class pixel_scoreboard;
	// copy of the config registers
	int unsigned          fwidth;
	int unsigned          fheight;
	dlr_pkg::color_mode_t cmode;
	longint               lo_h;
	longint               hi_h;
	// line state
	bit          active;
	longint      xacc;
	longint      yacc;
	longint      xinc;
	longint      yinc;
	longint      sidx;
	longint      stot;
	longint      tinc;
	longint      tacc;
	logic [23:0] col_a;
	logic [23:0] col_b;
	longint      hgt_a;
	longint      hgt_b;
	pixel_beat_t pending[$];
	int          errors;

	function new();
		fwidth = 1024; fheight = 768; cmode = dlr_pkg::CM_CONST; lo_h = 0; hi_h = 255;
		active = 0; errors = 0;
	endfunction

	function void set_reg(dlr_pkg::reg_idx_t r, logic [31:0] v);
		case (r)
			dlr_pkg::REG_FRAME_WIDTH:  fwidth = v[12:0];
			dlr_pkg::REG_FRAME_HEIGHT: fheight = v[12:0];
			dlr_pkg::REG_COLOR_MODE:   cmode = dlr_pkg::color_mode_t'(v[1:0]);
			dlr_pkg::REG_LOWEST:       lo_h = $signed(v[15:0]);
			default:                   hi_h = $signed(v[15:0]);
		endcase
	endfunction

	static function longint div_toward_zero(longint n, longint d);
		if (n < 0)
			return -((-n) / d);
		return n / d;
	endfunction

	static function longint rounded_increment(longint delta, longint steps);
		longint mag;
		longint q;
		mag = delta < 0 ? -delta : delta;
		q = (mag * 65536 + steps / 2) / steps;
		return delta < 0 ? -q : q;
	endfunction

	function logic [23:0] blend_color(longint t);
		logic [23:0] res;
		longint c1;
		longint c2;
		longint c;
		res = '0;
		for (int sh = 0; sh < 24; sh += 8) begin
			c1 = (col_a >> sh) & 8'hFF;
			c2 = (col_b >> sh) & 8'hFF;
			c = c1 + div_toward_zero((c2 - c1) * t, 65536);
			res |= (24'(c) & 24'hFF) << sh;
		end
		return res;
	endfunction

	function logic [23:0] hue_color(longint t);
		longint one;
		longint sixty;
		longint z;
		longint den;
		longint num;
		longint hue;
		longint r;
		longint g;
		one = 65536;
		sixty = 60 * one;
		z = hgt_a * one + (hgt_b - hgt_a) * t;
		den = hi_h - lo_h;
		if (den == 0) begin
			hue = 120 * one;
		end else begin
			num = (z - lo_h * one) * 120;
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			hue = 120 * one - div_toward_zero(num, den);
		end
		if (hue < 0) hue = 0;
		if (hue > 120 * one) hue = 120 * one;
		if (hue < sixty) begin
			r = 255;
			g = (hue * 255) / sixty;
		end else begin
			r = ((sixty - (hue - sixty)) * 255) / sixty;
			g = 255;
		end
		return {8'(r), 8'(g), 8'h00};
	endfunction

	// accepted input beat: load a line or predict one pixel
	function void note_input(logic m, logic [15:0] xs, logic [15:0] ys, logic [15:0] xe,
			logic [15:0] ye, logic [23:0] ca, logic [23:0] cb, logic [15:0] ha,
			logic [15:0] hb);
		longint dx;
		longint dy;
		longint steps;
		longint px;
		longint py;
		pixel_beat_t b;
		if (m == dlr_pkg::MODE_LOAD) begin
			dx = longint'($signed(xe)) - $signed(xs);
			dy = longint'($signed(ye)) - $signed(ys);
			steps = (dx < 0 ? -dx : dx);
			if ((dy < 0 ? -dy : dy) > steps) steps = dy < 0 ? -dy : dy;
			col_a = ca; col_b = cb;
			hgt_a = $signed(ha); hgt_b = $signed(hb);
			xacc = longint'($signed(xs)) * 65536;
			yacc = longint'($signed(ys)) * 65536;
			sidx = 0; tacc = 0; stot = steps;
			active = steps != 0;
			if (active) begin
				xinc = rounded_increment(dx, steps);
				yinc = rounded_increment(dy, steps);
				tinc = 65536 / steps;
			end
			return;
		end
		if (!active)
			return;
		// rounded coordinate is floor(acc + half)
		px = (xacc + 32768) >>> 16;
		py = (yacc + 32768) >>> 16;
		b.px = 16'(px);
		b.py = 16'(py);
		b.hit = px >= 0 && py >= 0 && px < fwidth && py < fheight;
		b.idx = b.hit ? 24'(py * fwidth + px) : '0;
		b.fin = sidx + 1 >= stot;
		case (cmode)
			dlr_pkg::CM_CONST: b.color = dlr_pkg::CYAN;
			dlr_pkg::CM_BLEND: b.color = blend_color(tacc);
			dlr_pkg::CM_HUE:   b.color = hue_color(tacc);
			default:           b.color = dlr_pkg::WHITE;
		endcase
		pending.push_back(b);
		xacc += xinc; yacc += yinc; sidx++; tacc += tinc;
		if (b.fin) active = 0;
	endfunction

	task report(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task check_pixel(pixel_beat_t got);
		pixel_beat_t want;
		if (pending.size() == 0) begin
			report("unexpected pixel beat", longint'(got.px), 0);
			return;
		end
		want = pending.pop_front();
		if (got.px !== want.px) report("pixel_x", got.px, want.px);
		if (got.py !== want.py) report("pixel_y", got.py, want.py);
		if (got.idx !== want.idx) report("pixel_index", got.idx, want.idx);
		if (got.hit !== want.hit) report("in_frame", got.hit, want.hit);
		if (got.color !== want.color) report("pixel_color", got.color, want.color);
		if (got.fin !== want.fin) report("last", got.fin, want.fin);
	endtask
endclass

module dda_line_rasterizer_unit_tb;
	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [15:0] x_start;
	logic [15:0] y_start;
	logic [15:0] x_end;
	logic [15:0] y_end;
	logic [23:0] color_start;
	logic [23:0] color_end;
	logic [15:0] height_start;
	logic [15:0] height_end;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic [23:0] pixel_index;
	logic        in_frame;
	logic [23:0] pixel_color;
	logic        last;

	pixel_scoreboard sb;
	int          send_idle_pct;   // chance in percent of an idle cycle on the input side
	int          recv_stall_pct;  // chance in percent of a stall cycle on the output side
	int          hold_off;        // cycles of forced receiver stall still to run
	longint      cycles = 0;
	localparam longint CYCLE_LIMIT = 2_000_000;

	dda_line_rasterizer_unit DUT (.*);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stalls plus an optional long hold-off, changed at the falling edge
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// pixel beats checked at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel({pixel_x, pixel_y, pixel_index, in_frame, pixel_color, last});
	end

	// apb write with setup and access phases, register lands at the access edge
	task write_reg(dlr_pkg::reg_idx_t r, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(r) << 2; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(r, v);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// one beat on the input channel, with a random idle gap before it;
	// valid stays up afterwards so back-to-back beats need no gap
	task send_beat(logic m, logic [15:0] xs, logic [15:0] ys, logic [15:0] xe,
			logic [15:0] ye, logic [23:0] ca, logic [23:0] cb, logic [15:0] ha,
			logic [15:0] hb);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1; mode <= m;
		x_start <= xs; y_start <= ys; x_end <= xe; y_end <= ye;
		color_start <= ca; color_end <= cb; height_start <= ha; height_end <= hb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(m, xs, ys, xe, ye, ca, cb, ha, hb);
		@(negedge clk);
	endtask

	task step_beat();
		send_beat(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// drop valid, wait until every predicted pixel is out, then let a stray
	// divider pass finish
	task drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		@(negedge clk);
	endtask

	// load a short random line, mostly near the frame, then walk it
	task random_line();
		logic [15:0] xs;
		logic [15:0] ys;
		int len;
		int extra;
		len = $urandom_range(1, 20);
		if ($urandom_range(9) == 0) begin
			xs = 16'($urandom);
			ys = 16'($urandom);
		end else begin
			xs = 16'($signed($urandom_range(0, 140)) - 20);
			ys = 16'($signed($urandom_range(0, 140)) - 20);
		end
		send_beat(1'b0, xs, ys,
			xs + 16'($signed($urandom_range(0, 2 * len)) - len),
			ys + 16'($signed($urandom_range(0, 2 * len)) - len),
			24'($urandom), 24'($urandom),
			16'($signed($urandom_range(0, 600)) - 300),
			16'($signed($urandom_range(0, 600)) - 300));
		// sometimes cut the line short or overrun it
		extra = $urandom_range(0, 3);
		for (int k = 0; k < len + extra - 2 + int'($urandom_range(0, 2)); k++)
			step_beat();
	endtask

	initial begin
		sb = new();
		hold_off = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; mode = 1'b0;
		x_start = '0; y_start = '0; x_end = '0; y_end = '0;
		color_start = '0; color_end = '0; height_start = '0; height_end = '0;
		out_stall = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: step while idle, zero-length line, extremes, every mode
		step_beat();
		send_beat(1'b0, 16'd5, 16'd5, 16'd5, 16'd5, 24'h0, 24'hFFFFFF, 16'd0, 16'd0);
		step_beat();
		send_beat(1'b0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
			24'hFFFFFF, 24'h000000, 16'h8000, 16'h7FFF);
		repeat (3) step_beat();
		drain();
		write_reg(dlr_pkg::REG_COLOR_MODE, dlr_pkg::CM_BLEND);
		send_beat(1'b0, 16'hFFFE, 16'd3, 16'd4, 16'hFFFF,
			24'h00FF80, 24'hFF0080, 16'd0, 16'd255);
		repeat (7) step_beat();
		drain();
		write_reg(dlr_pkg::REG_COLOR_MODE, dlr_pkg::CM_HUE);
		send_beat(1'b0, 16'd0, 16'd0, 16'd3, 16'd1, 24'h0, 24'h0, 16'hFFF0, 16'd400);
		repeat (3) step_beat();
		drain();
		// equal bounds, then reversed bounds, then extremes
		write_reg(dlr_pkg::REG_HIGHEST, 32'd0);
		send_beat(1'b0, 16'd1, 16'd1, 16'd3, 16'd3, 24'h0, 24'h0, 16'd10, 16'd90);
		repeat (2) step_beat();
		drain();
		write_reg(dlr_pkg::REG_LOWEST, 32'd200);
		send_beat(1'b0, 16'd1, 16'd1, 16'd4, 16'd1, 24'h0, 24'h0, 16'd0, 16'd300);
		repeat (3) step_beat();
		drain();
		write_reg(dlr_pkg::REG_LOWEST, 32'h8000);
		write_reg(dlr_pkg::REG_HIGHEST, 32'h7FFF);
		write_reg(dlr_pkg::REG_FRAME_WIDTH, 32'd1);
		write_reg(dlr_pkg::REG_FRAME_HEIGHT, 32'd4096);
		send_beat(1'b0, 16'd0, 16'd0, 16'd1, 16'd3, 24'h0, 24'h0, 16'h8000, 16'h7FFF);
		repeat (3) step_beat();
		drain();
		write_reg(dlr_pkg::REG_COLOR_MODE, dlr_pkg::CM_WHITE);
		write_reg(dlr_pkg::REG_FRAME_WIDTH, 32'd4096);
		write_reg(dlr_pkg::REG_FRAME_HEIGHT, 32'd1);
		send_beat(1'b0, 16'd4094, 16'd0, 16'd4097, 16'd1, 24'h0, 24'h0, 16'd0, 16'd0);
		repeat (3) step_beat();
		drain();

		// random phases: mostly receiver stalls, then mostly sender idles, then neither
		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 71 : 0;
			recv_stall_pct = (ph < 2) ? 71 : (ph < 4) ? 32 : 0;
			write_reg(dlr_pkg::REG_COLOR_MODE, $urandom_range(3));
			write_reg(dlr_pkg::REG_FRAME_WIDTH, (ph == 1) ? 1 : $urandom_range(1, 200));
			write_reg(dlr_pkg::REG_FRAME_HEIGHT, (ph == 3) ? 4096 : $urandom_range(1, 200));
			write_reg(dlr_pkg::REG_LOWEST, 32'($signed($urandom_range(0, 400)) - 300));
			write_reg(dlr_pkg::REG_HIGHEST, 32'($signed($urandom_range(0, 400)) - 100));
			if (ph == 4)
				hold_off = 400;   // receiver backs up while lines keep coming
			for (int n = 0; n < 11; n++)
				random_line();
			drain();   // sender pause until all pixels are in
		end

		// restore default frame and heights so the reset-valued settings also get exercised, in hue mode
		write_reg(dlr_pkg::REG_FRAME_WIDTH, 32'd1024);
		write_reg(dlr_pkg::REG_FRAME_HEIGHT, 32'd768);
		write_reg(dlr_pkg::REG_LOWEST, 32'd0);
		write_reg(dlr_pkg::REG_HIGHEST, 32'd255);
		write_reg(dlr_pkg::REG_COLOR_MODE, dlr_pkg::CM_HUE);
		for (int n = 0; n < 5; n++)
			random_line();
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
